@@ rtl/pngu_pkg.sv @@
package pngu_pkg;

    // Default widest row in pixels, and the depth of the queue between front and back.
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int QUEUE_DEPTH   = 4;

    // Configuration port widths and register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    // Alpha of an image that carries no alpha channel.
    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

    // Row filter types.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    // One classified sample byte, as the front hands it to the back.
    typedef struct packed {
        logic [7:0] raw;
        t_filter    filter;
        logic [1:0] lane;
        logic       first_row;
        logic       pixel_last;
        logic       row_last;
        logic       image_last;
        logic       rgb;
    } t_byte_tag;

endpackage

@@ rtl/pngu_ram.sv @@
module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pngu_front.sv @@
module pngu_front #(
    parameter int MAX_WIDTH = 4096,
    localparam int CW = $clog2(MAX_WIDTH * 4)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic [7:0]                           i_raw_byte,
    input  logic                                 i_full,
    output logic                                 o_push,
    output pngu_pkg::t_byte_tag                  o_tag,
    output logic [CW-1:0]                        o_col,
    input  logic                                 i_cfg_valid,
    input  logic [pngu_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_cfg_ready
);

    import pngu_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int XW = CW + 1;

    logic          r_await, n_await;
    t_filter       r_filter, n_filter;
    logic [CW-1:0] r_col, n_col;
    logic [1:0]    r_mod3, n_mod3;
    logic [15:0]   r_row, n_row;
    logic [12:0]   r_width, n_width;
    logic [15:0]   r_height, n_height;
    logic          r_alpha, n_alpha;

    logic          accept;
    logic [1:0]    lane;
    logic [1:0]    last_lane;
    logic          pixel_last;
    logic          row_last;
    logic          image_last;
    logic [31:0]   w_ext;
    logic [WW-1:0] w_eff;
    logic [XW-1:0] w_wide;
    logic [XW-1:0] stride;
    logic [XW-1:0] col_inc;
    logic [15:0]   h_eff;
    logic [16:0]   row_inc;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !i_full;

    // Place of the byte in its pixel, for either pixel size.
    assign lane       = r_alpha ? r_col[1:0] : r_mod3;
    assign last_lane  = r_alpha ? 2'd3 : 2'd2;
    assign pixel_last = (lane == last_lane);

    // Row length in bytes, from the width clamped into its legal range.
    always_comb begin
        w_ext = 32'(r_width);
        if (w_ext == 32'd0) begin
            w_eff = WW'(1);
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_width);
        end
        w_wide = XW'(w_eff);
        stride = r_alpha ? (w_wide << 2) : ((w_wide << 1) + w_wide);
    end

    // Row and image ends.
    assign col_inc    = XW'(r_col) + XW'(1);
    assign h_eff      = (r_height == 16'd0) ? 16'd1 : r_height;
    assign row_inc    = 17'(r_row) + 17'd1;
    assign row_last   = pixel_last && (col_inc >= stride);
    assign image_last = row_last && (row_inc >= 17'(h_eff));

    // Tag handed to the back for each sample byte.
    always_comb begin
        o_push           = accept && !r_await;
        o_col            = r_col;
        o_tag.raw        = i_raw_byte;
        o_tag.filter     = r_filter;
        o_tag.lane       = lane;
        o_tag.first_row  = (r_row == 16'd0);
        o_tag.pixel_last = pixel_last;
        o_tag.row_last   = row_last;
        o_tag.image_last = image_last;
        o_tag.rgb        = !r_alpha;
    end

    // Stream position: filter byte, then sample bytes up to the row end.
    always_comb begin
        n_await  = r_await;
        n_filter = r_filter;
        n_col    = r_col;
        n_mod3   = r_mod3;
        n_row    = r_row;
        if (accept) begin
            if (r_await) begin
                n_filter = (i_raw_byte > 8'd4) ? FILT_NONE : t_filter'(i_raw_byte[2:0]);
                n_await  = 1'b0;
                n_col    = '0;
                n_mod3   = 2'd0;
            end else if (row_last) begin
                n_await = 1'b1;
                n_col   = '0;
                n_mod3  = 2'd0;
                n_row   = image_last ? 16'd0 : row_inc[15:0];
            end else begin
                n_col  = col_inc[CW-1:0];
                n_mod3 = (r_mod3 == 2'd2) ? 2'd0 : r_mod3 + 2'd1;
            end
        end
    end

    // Configuration registers.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_alpha  = r_alpha;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  n_width  = i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT: n_height = i_cfg_data[15:0];
                CFG_HAS_ALPHA:    n_alpha  = i_cfg_data[0];
                default:          n_width  = r_width;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_filter <= FILT_NONE;
            r_col    <= '0;
            r_mod3   <= 2'd0;
            r_row    <= 16'd0;
            r_width  <= 13'd1;
            r_height <= 16'd1;
            r_alpha  <= 1'b1;
        end else begin
            r_await  <= n_await;
            r_filter <= n_filter;
            r_col    <= n_col;
            r_mod3   <= n_mod3;
            r_row    <= n_row;
            r_width  <= n_width;
            r_height <= n_height;
            r_alpha  <= n_alpha;
        end
    end

endmodule

@@ rtl/pngu_queue.sv @@
module pngu_queue #(
    parameter int DEPTH = 4,
    parameter int COL_W = 14,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pngu_pkg::t_byte_tag i_push_tag,
    input  logic [COL_W-1:0]    i_push_col,
    output logic                o_full,
    input  logic                i_pop,
    output pngu_pkg::t_byte_tag o_pop_tag,
    output logic [COL_W-1:0]    o_pop_col,
    output logic                o_empty
);

    import pngu_pkg::*;

    t_byte_tag        r_tag_mem [DEPTH];
    logic [COL_W-1:0] r_col_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_count, n_count;

    assign o_full    = (r_count == NW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_tag = r_tag_mem[r_rd_ptr];
    assign o_pop_col = r_col_mem[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_tag_mem[r_wr_ptr] <= i_push_tag;
            r_col_mem[r_wr_ptr] <= i_push_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/pngu_back.sv @@
module pngu_back #(
    parameter int MAX_WIDTH = 4096,
    localparam int CW = $clog2(MAX_WIDTH * 4)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  pngu_pkg::t_byte_tag i_tag,
    input  logic [CW-1:0]       i_col,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_alpha,
    output logic                o_end_of_row,
    output logic                o_end_of_image
);

    import pngu_pkg::*;

    // Paeth predictor: the neighbor nearest to left + above - upper-left.
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = pa + pb;
        if (pa < 0) pa = -pa;
        if (pb < 0) pb = -pb;
        if (pc < 0) pc = -pc;
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

    logic          r_a_valid, n_a_valid;
    t_byte_tag     r_a_tag;
    logic [CW-1:0] r_a_col;
    logic [31:0]   r_left, n_left;
    logic [31:0]   r_upper, n_upper;
    logic [31:0]   r_up_acc, n_up_acc;
    logic [23:0]   r_asm, n_asm;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_pix;
    logic          r_out_eor;
    logic          r_out_eoi;

    logic          out_free;
    logic          a_fire;
    logic          out_load;
    logic [7:0]    ram_q;
    logic [4:0]    sh;
    logic [7:0]    a_byte;
    logic [7:0]    b_byte;
    logic [7:0]    c_byte;
    logic [8:0]    avg_sum;
    logic [7:0]    pred;
    logic [7:0]    v;
    logic [31:0]   pix;
    logic [31:0]   up_word;

    // Handshake between queue, compute stage and output register.
    assign out_free = !r_out_valid || !i_out_stall;
    assign a_fire   = r_a_valid && (!r_a_tag.pixel_last || out_free);
    assign out_load = a_fire && r_a_tag.pixel_last;
    assign o_pop    = !i_empty && (!r_a_valid || a_fire);

    // Line store: read the byte above on pop, write the new byte when it is done.
    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH * 4)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (a_fire),
        .i_waddr (r_a_col),
        .i_wdata (v),
        .i_re    (o_pop),
        .i_raddr (i_col),
        .o_rdata (ram_q)
    );

    // Neighbors of the current byte and the filter reconstruction.
    always_comb begin
        sh      = {r_a_tag.lane, 3'b000};
        a_byte  = r_left[sh +: 8];
        c_byte  = r_upper[sh +: 8];
        b_byte  = r_a_tag.first_row ? 8'd0 : ram_q;
        avg_sum = 9'(a_byte) + 9'(b_byte);
        case (r_a_tag.filter)
            FILT_SUB:   pred = a_byte;
            FILT_UP:    pred = b_byte;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH: pred = paeth(a_byte, b_byte, c_byte);
            default:    pred = 8'd0;
        endcase
        v       = r_a_tag.raw + pred;
        up_word = r_up_acc | (32'(b_byte) << sh);
        pix     = {8'h00, r_asm} | (32'(v) << sh);
        if (r_a_tag.rgb) begin
            pix[31:24] = OPAQUE_ALPHA;
        end
    end

    // Pixel assembly and the left and upper-left pixels.
    always_comb begin
        n_left   = r_left;
        n_upper  = r_upper;
        n_up_acc = r_up_acc;
        n_asm    = r_asm;
        if (a_fire) begin
            if (!r_a_tag.pixel_last) begin
                n_asm    = r_asm | pix[23:0];
                n_up_acc = up_word;
            end else begin
                n_asm    = 24'd0;
                n_up_acc = 32'd0;
                n_left   = r_a_tag.row_last ? 32'd0 : pix;
                n_upper  = r_a_tag.row_last ? 32'd0 : up_word;
            end
        end
    end

    // Stage and output valid flags.
    always_comb begin
        n_a_valid = r_a_valid;
        if (o_pop) begin
            n_a_valid = 1'b1;
        end else if (a_fire) begin
            n_a_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_tag <= i_tag;
            r_a_col <= i_col;
        end
        if (out_load) begin
            r_out_pix <= pix;
            r_out_eor <= r_a_tag.row_last;
            r_out_eoi <= r_a_tag.image_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= 32'd0;
            r_upper     <= 32'd0;
            r_up_acc    <= 32'd0;
            r_asm       <= 24'd0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            r_upper     <= n_upper;
            r_up_acc    <= n_up_acc;
            r_asm       <= n_asm;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_out_pix[7:0];
    assign o_green        = r_out_pix[15:8];
    assign o_blue         = r_out_pix[23:16];
    assign o_alpha        = r_out_pix[31:24];
    assign o_end_of_row   = r_out_eor;
    assign o_end_of_image = r_out_eoi;

endmodule

@@ rtl/png_scanline_unfilter.sv @@
// A pixel's bytes pass through the queue and the compute stage into the output register.
// Throughput: one byte per cycle unless the output stalls, set by the line store's single
// read and single write port, which each sample byte uses once; filter bytes produce no pixel.
// Reset (synchronous, active low) clears the stream position, row counter, queue,
// pipeline and pixel state; the line store is not cleared and its data is unused in row zero.
module png_scanline_unfilter #(
    parameter int MAX_WIDTH = pngu_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_raw_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_red,
    output logic [7:0]                       o_green,
    output logic [7:0]                       o_blue,
    output logic [7:0]                       o_alpha,
    output logic                             o_end_of_row,
    output logic                             o_end_of_image,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pngu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pngu_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import pngu_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH * 4);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    t_byte_tag     push_tag;
    t_byte_tag     pop_tag;
    logic [CW-1:0] push_col;
    logic [CW-1:0] pop_col;

    assign o_in_stall = q_full;

    // Front: stream position, filter type and row bookkeeping.
    pngu_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_raw_byte  (i_raw_byte),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_tag       (push_tag),
        .o_col       (push_col),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // Queue of classified sample bytes.
    pngu_queue #(
        .DEPTH (QUEUE_DEPTH),
        .COL_W (CW)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_tag (push_tag),
        .i_push_col (push_col),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_pop_tag  (pop_tag),
        .o_pop_col  (pop_col),
        .o_empty    (q_empty)
    );

    // Back: line store, reconstruction and output register.
    pngu_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_tag          (pop_tag),
        .i_col          (pop_col),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_alpha        (o_alpha),
        .o_end_of_row   (o_end_of_row),
        .o_end_of_image (o_end_of_image)
    );

endmodule
